// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int BUDGET_W    = 24;
    localparam int JOB_BYTES   = 13;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'h010000;

    // characters that the escaper emits
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // control codes with a short escape
    localparam logic [15:0] CC_BS = 16'h0008;
    localparam logic [15:0] CC_HT = 16'h0009;
    localparam logic [15:0] CC_LF = 16'h000a;
    localparam logic [15:0] CC_FF = 16'h000c;
    localparam logic [15:0] CC_CR = 16'h000d;

    localparam logic [15:0] HIGH_SURR_LO = 16'hd800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hdbff;
    localparam logic [15:0] LOW_SURR_LO  = 16'hdc00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hdfff;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;

    // one queued job: the packed bytes of an item, how many go out, and
    // whether an overflow result follows them
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          n_bytes;
        logic                      ovf;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

    function automatic logic [5:0][7:0] u_escape(input logic [15:0] v);
        logic [5:0][7:0] b;
        b[0] = CH_BSLASH;
        b[1] = CH_LOWER_U;
        b[2] = hex_char(v[15:12]);
        b[3] = hex_char(v[11:8]);
        b[4] = hex_char(v[7:4]);
        b[5] = hex_char(v[3:0]);
        return b;
    endfunction

endpackage

// ===== design/jsu_front.sv =====
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [BUDGET_W-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic [15:0]         i_code_unit,
    input  logic                i_wide_chars,
    input  logic                i_carries_unit,
    input  logic                i_first_unit,
    input  logic                i_last_unit,
    input  logic                i_new_document,
    output logic                o_push,
    output t_job                o_job
);

    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] r_count, n_count;
    logic                r_stopped, n_stopped;
    logic                r_held_valid, n_held_valid;
    logic [15:0]         r_held, n_held;

    logic                stopped_eff;
    logic [BUDGET_W-1:0] count_eff;
    logic                held_v0;
    logic [15:0]         u;
    logic                is_low, is_high, is_surr;
    logic                pair, flush, hold_new, unit_emit;
    logic [20:0]         cp;
    logic [5:0][7:0]     ub;
    logic [5:0][7:0]     hesc;
    logic [2:0]          uk;
    logic                usplit;
    logic [CNT_W-1:0]    p_held, p_unit, p_close, total;
    logic [BUDGET_W-1:0] room;
    logic [CNT_W-1:0]    room4;
    logic [CNT_W-1:0]    n_emit;
    logic                fail;

    // state as seen by this item after new_document / first_unit clears
    assign stopped_eff = r_stopped & ~i_new_document;
    assign count_eff   = i_new_document ? '0 : r_count;
    assign held_v0     = r_held_valid & ~i_new_document & ~i_first_unit;

    assign u       = i_wide_chars ? i_code_unit : {8'h00, i_code_unit[7:0]};
    assign is_surr = (u >= HIGH_SURR_LO) && (u <= LOW_SURR_HI);
    assign is_high = i_wide_chars && (u >= HIGH_SURR_LO) && (u <= HIGH_SURR_HI);
    assign is_low  = i_wide_chars && (u >= LOW_SURR_LO) && (u <= LOW_SURR_HI);

    assign pair      = i_carries_unit & held_v0 & is_low;
    assign hold_new  = i_carries_unit & ~pair & is_high & ~i_last_unit;
    // a held unit is flushed before another unit, or before the closing quote
    assign flush     = held_v0 & ((i_carries_unit & ~pair) | (~i_carries_unit & i_last_unit));
    assign unit_emit = i_carries_unit & ~hold_new;

    assign cp   = SUPP_BASE + {1'b0, r_held[9:0], u[9:0]};
    assign hesc = u_escape(r_held);

    always_comb begin
        ub     = '0;
        uk     = 3'd0;
        usplit = 1'b0;
        priority if (pair) begin
            ub[0] = {5'b11110, cp[20:18]};
            ub[1] = {2'b10, cp[17:12]};
            ub[2] = {2'b10, cp[11:6]};
            ub[3] = {2'b10, cp[5:0]};
            uk    = 3'd4;
        end else if (is_surr) begin
            ub = u_escape(u);
            uk = 3'd6;
        end else if (u == {8'h00, CH_QUOTE} || u == {8'h00, CH_BSLASH}) begin
            // two separate one-byte chunks
            ub[0]  = CH_BSLASH;
            ub[1]  = u[7:0];
            uk     = 3'd2;
            usplit = 1'b1;
        end else if (u == CC_BS) begin
            ub[0] = CH_BSLASH;
            ub[1] = CH_LOWER_B;
            uk    = 3'd2;
        end else if (u == CC_FF) begin
            ub[0] = CH_BSLASH;
            ub[1] = CH_LOWER_F;
            uk    = 3'd2;
        end else if (u == CC_LF) begin
            ub[0] = CH_BSLASH;
            ub[1] = CH_LOWER_N;
            uk    = 3'd2;
        end else if (u == CC_CR) begin
            ub[0] = CH_BSLASH;
            ub[1] = CH_LOWER_R;
            uk    = 3'd2;
        end else if (u == CC_HT) begin
            ub[0] = CH_BSLASH;
            ub[1] = CH_LOWER_T;
            uk    = 3'd2;
        end else if (u < 16'h0020) begin
            ub = u_escape(u);
            uk = 3'd6;
        end else if (u < 16'h0080) begin
            ub[0] = u[7:0];
            uk    = 3'd1;
        end else if (u < 16'h0800) begin
            ub[0] = {3'b110, u[10:6]};
            ub[1] = {2'b10, u[5:0]};
            uk    = 3'd2;
        end else begin
            ub[0] = {4'b1110, u[15:12]};
            ub[1] = {2'b10, u[11:6]};
            ub[2] = {2'b10, u[5:0]};
            uk    = 3'd3;
        end
    end

    // chunk boundaries in the packed byte list
    assign p_held  = {3'b000, i_first_unit};
    assign p_unit  = p_held + (flush ? 4'd6 : 4'd0);
    assign p_close = p_unit + (unit_emit ? {1'b0, uk} : 4'd0);
    assign total   = p_close + {3'b000, i_last_unit};

    assign room  = (r_budget > count_eff) ? (r_budget - count_eff) : '0;
    assign room4 = (|room[BUDGET_W-1:CNT_W]) ? '1 : room[CNT_W-1:0];
    assign fail  = total > room4;

    // boundaries only grow, so the last one that fits wins
    always_comb begin
        n_emit = '0;
        if (i_first_unit && p_held <= room4) begin
            n_emit = p_held;
        end
        if (flush && p_unit <= room4) begin
            n_emit = p_unit;
        end
        if (unit_emit && usplit && (p_unit + 4'd1) <= room4) begin
            n_emit = p_unit + 4'd1;
        end
        if (unit_emit && p_close <= room4) begin
            n_emit = p_close;
        end
        if (i_last_unit && total <= room4) begin
            n_emit = total;
        end
    end

    always_comb begin
        for (int i = 0; i < JOB_BYTES; i++) begin
            o_job.bytes[i] = '0;
            if (i_first_unit && 4'(i) == 4'd0) begin
                o_job.bytes[i] = CH_QUOTE;
            end else if (flush && 4'(i) >= p_held && 4'(i) < p_unit) begin
                o_job.bytes[i] = hesc[3'(4'(i) - p_held)];
            end else if (unit_emit && 4'(i) >= p_unit && 4'(i) < p_close) begin
                o_job.bytes[i] = ub[3'(4'(i) - p_unit)];
            end else if (i_last_unit && 4'(i) == p_close) begin
                o_job.bytes[i] = CH_QUOTE;
            end
        end
    end

    assign o_job.n_bytes = n_emit;
    assign o_job.ovf     = fail;
    assign o_push        = i_accept & ~stopped_eff & (total != '0);

    always_comb begin
        n_count      = r_count;
        n_stopped    = r_stopped;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        if (i_accept && !stopped_eff) begin
            n_count   = count_eff + {{(BUDGET_W-CNT_W){1'b0}}, n_emit};
            n_stopped = fail;
            if (fail) begin
                n_held_valid = 1'b0;
            end else if (i_carries_unit) begin
                n_held_valid = hold_new;
            end else begin
                n_held_valid = held_v0 & ~i_last_unit;
            end
            if (hold_new) begin
                n_held = u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget     <= BUDGET_RESET;
            r_count      <= '0;
            r_stopped    <= 1'b0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            r_count      <= n_count;
            r_stopped    <= n_stopped;
            r_held_valid <= n_held_valid;
            r_held       <= n_held;
        end
    end

    a_stopped_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_stopped && !i_new_document |-> !o_push)
        else $error("item produced a job while stopped");

    a_overflow_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_job.ovf |=> r_stopped)
        else $error("overflow did not stop the document");

endmodule

// ===== design/jsu_queue.sv =====
`timescale 1ns / 1ps

module jsu_queue
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("job queue overrun or underrun");

endmodule

// ===== design/jsu_back.sv =====
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic       o_ovf
);

    logic [CNT_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_data;
    logic             r_last;
    logic             r_ovf;

    logic             load;
    logic [CNT_W-1:0] total;
    logic             is_byte;
    logic             at_end;

    assign total   = i_head.n_bytes + {{(CNT_W-1){1'b0}}, i_head.ovf};
    assign is_byte = r_idx < i_head.n_bytes;
    assign at_end  = (r_idx == total - 1'b1);
    assign load    = ~i_empty & (~r_valid | i_ready);
    assign o_pop   = load & at_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= is_byte ? i_head.bytes[r_idx] : 8'h00;
            r_ovf  <= ~is_byte;
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_ovf   = r_ovf;

    a_ovf_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_ovf |-> r_data == 8'h00 && r_last)
        else $error("overflow result must be last and carry zero");

endmodule

// ===== design/json_string_utf8_escaper_unit.sv =====
`timescale 1ns / 1ps
// path: an item is queued as a job, then its bytes are registered at the output
// throughput: one item per cycle in while the queue is not full; the byte serializer
// sends one result per cycle while m_axis_tready is high, so an item holds the back
// end until its results are sent; a 4-job queue lets the input take items meanwhile
// reset: synchronous active low; budget returns to 65536, count, stop and held
// surrogate clear, queue empties

module json_string_utf8_escaper_unit
    import jsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BUDGET_W-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,  // code_unit, first_unit, new_document, zero pad
    input  logic [1:0]          s_axis_tuser,  // wide_chars, carries_unit
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,  // out_byte
    output logic                m_axis_tuser,  // overflow
    output logic                m_axis_tlast
);

    logic accept;
    logic push, pop, empty, full;
    t_job job, head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_code_unit    (s_axis_tdata[15:0]),
        .i_wide_chars   (s_axis_tuser[0]),
        .i_carries_unit (s_axis_tuser[1]),
        .i_first_unit   (s_axis_tdata[16]),
        .i_last_unit    (s_axis_tlast),
        .i_new_document (s_axis_tdata[17]),
        .o_push         (push),
        .o_job          (job)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_ovf   (m_axis_tuser)
    );

endmodule
